FILE: hw/rtl/efd_pkg.sv
// Package: shared codes and types for the escape/start frame deframer.
`timescale 1ns / 1ps

package efd_pkg;

	// Byte and code widths
	localparam int ByteW  = 8;
	localparam int KindW  = 2;
	localparam int PhaseW = 2;
	localparam int IdxW   = 8;

	// Register reset values
	localparam logic [ByteW-1:0] EscapeRst = 8'h48;
	localparam logic [ByteW-1:0] StartRst  = 8'h10;

	// Register indexes
	localparam logic [IdxW-1:0] REG_ESCAPE = 8'd0;
	localparam logic [IdxW-1:0] REG_START  = 8'd1;

	// Hunt/frame phase codes
	localparam logic [PhaseW-1:0] PH_HUNT      = 2'd0;
	localparam logic [PhaseW-1:0] PH_HUNT_ESC  = 2'd1;
	localparam logic [PhaseW-1:0] PH_FRAME     = 2'd2;
	localparam logic [PhaseW-1:0] PH_FRAME_ESC = 2'd3;

	// Result kinds
	localparam logic [KindW-1:0] KIND_DATA  = 2'd0;
	localparam logic [KindW-1:0] KIND_DONE  = 2'd1;
	localparam logic [KindW-1:0] KIND_ABORT = 2'd2;

	// One result beat from the decoder
	typedef struct packed {
		logic             emit;
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] data;
	} res_t;

endpackage

FILE: hw/rtl/efd_in_stage.sv
// Input register stage: holds one received byte until the decoder takes it.
`timescale 1ns / 1ps

module efd_in_stage import efd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] in_byte,
	input  logic             adv,
	output logic             valid_s1,
	output logic [ByteW-1:0] byte_s1
);

	// Free when empty or when the held beat moves on this cycle
	assign in_ready = !valid_s1 || adv;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

FILE: hw/rtl/efd_decode.sv
// Deframing state machine: phase and frame-has-data flags, one byte per step.
`timescale 1ns / 1ps

module efd_decode import efd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [ByteW-1:0] byte_s1,
	input  logic [ByteW-1:0] escape_q,
	input  logic [ByteW-1:0] start_q,
	output res_t             res
);

	logic [PhaseW-1:0] phase_q;
	logic [PhaseW-1:0] phase_d;
	logic              has_data_q;
	logic              has_data_d;
	logic              is_esc;
	logic              is_start;

	assign is_esc   = (byte_s1 == escape_q);
	assign is_start = (byte_s1 == start_q);

	// Next state and result; start check wins over escape after an escape
	always_comb begin
		phase_d    = phase_q;
		has_data_d = has_data_q;
		res.emit   = 1'b0;
		res.kind   = KIND_DATA;
		res.data   = '0;
		case (phase_q)
			PH_HUNT: begin
				if (is_esc) begin
					phase_d = PH_HUNT_ESC;
				end
			end
			PH_HUNT_ESC: begin
				if (is_start) begin
					phase_d    = PH_FRAME;
					has_data_d = 1'b0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_FRAME: begin
				if (is_esc) begin
					phase_d = PH_FRAME_ESC;
				end else begin
					has_data_d = 1'b1;
					res.emit   = 1'b1;
					res.data   = byte_s1;
				end
			end
			PH_FRAME_ESC: begin
				if (is_start) begin
					// close; empty frames report nothing
					phase_d    = PH_HUNT;
					has_data_d = 1'b0;
					res.emit   = has_data_q;
					res.kind   = KIND_DONE;
				end else if (is_esc) begin
					// doubled escape is a literal byte
					phase_d    = PH_FRAME;
					has_data_d = 1'b1;
					res.emit   = 1'b1;
					res.data   = byte_s1;
				end else begin
					phase_d    = PH_HUNT;
					has_data_d = 1'b0;
					res.emit   = has_data_q;
					res.kind   = KIND_ABORT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// State registers advance only when a byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			has_data_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			has_data_q <= has_data_d;
		end
	end

endmodule

FILE: hw/rtl/efd_out_stage.sv
// Output register stage: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps

module efd_out_stage import efd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  res_t             res,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [KindW-1:0] out_kind,
	output logic [ByteW-1:0] out_byte
);

	// Room for a new beat when empty or draining this cycle
	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res.emit) begin
			out_kind <= res.kind;
			out_byte <= res.data;
		end
	end

endmodule

FILE: hw/rtl/escape_sof_frame_deframer.sv
// Top level: escape/start byte-stuffed frame deframer.
//
// Input channel in_valid/in_ready/in_byte carries one received byte per beat.
// Output channel out_valid/out_ready carries at most one result per input
// byte: out_kind is a payload byte (out_byte holds it), frame completed or
// frame aborted (out_byte is zero). Escape then start opens a frame; inside
// it escape-escape is a literal escape byte, escape-start closes, escape then
// anything else aborts. Empty frames report nothing.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 escape byte,
// 1 start byte); other indexes are ignored. Write only while idle.
// Path: an accepted byte waits in the input register, and its result is
// registered in the output register as soon as that register has room.
// Throughput: one byte per cycle while out_ready stays high, set by the single
// decode step between the input register and the output register.
// Reset: clears both stages and returns to hunting with escape 0x48 and
// start 0x10. When the receiver stalls, the output register holds its beat,
// one more byte waits in the input register, then in_ready drops.
`timescale 1ns / 1ps

module escape_sof_frame_deframer import efd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_idx,
	input  logic [ByteW-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [KindW-1:0] out_kind,
	output logic [ByteW-1:0] out_byte
);

	logic [ByteW-1:0] escape_q;
	logic [ByteW-1:0] start_q;
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_free;
	logic             adv;
	res_t             res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= EscapeRst;
			start_q  <= StartRst;
		end else if (cfg_we) begin
			if (cfg_idx == REG_ESCAPE) begin
				escape_q <= cfg_wdata;
			end
			if (cfg_idx == REG_START) begin
				start_q <= cfg_wdata;
			end
		end
	end

	// Held byte moves on whenever the output register has room
	assign adv = valid_s1 && out_free;

	efd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	efd_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.byte_s1  (byte_s1),
		.escape_q (escape_q),
		.start_q  (start_q),
		.res      (res)
	);

	efd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte)
	);

endmodule

FILE: hw/rtl/efd_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
`timescale 1ns / 1ps

module efd_checker import efd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [KindW-1:0] out_kind,
	input logic [ByteW-1:0] out_byte
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte))
		else $error("result beat changed while stalled");

	// Markers carry a zero byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_DONE || out_kind == KIND_ABORT) |-> out_byte == '0)
		else $error("frame marker with nonzero byte");

	// A fresh result follows an earlier accepted input byte
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input beat");

	// Input never blocks while the output side is empty
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind escape_sof_frame_deframer efd_checker u_efd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_kind  (out_kind),
	.out_byte  (out_byte)
);

FILE: verif/tb_escape_sof_frame_deframer.sv
// Testbench for the escape/start byte-stuffed frame deframer: directed and random frames.
`timescale 1ns / 1ps

module tb_escape_sof_frame_deframer;
	import efd_pkg::*;

	localparam int ClkHalf      = 6;
	localparam int ResetCycles  = 5;
	localparam int SettleCycles = 6;
	localparam int CycleLimit   = 200000;

	// Indexes that map to no register; writes there must be dropped
	localparam logic [IdxW-1:0] REG_UNUSED_LO = 8'd2;
	localparam logic [IdxW-1:0] REG_UNUSED_HI = 8'hFF;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] data;
	} beat_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IdxW-1:0]  cfg_idx;
	logic [ByteW-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic [ByteW-1:0] in_byte;
	logic             out_valid;
	logic             out_ready;
	logic [KindW-1:0] out_kind;
	logic [ByteW-1:0] out_byte;

	// Predicted output beats, oldest first
	beat_t pending_beats[$];

	// Shadow of the deframer state and framing registers
	logic [PhaseW-1:0] model_phase;
	logic              model_has_data;
	logic [ByteW-1:0]  model_escape;
	logic [ByteW-1:0]  model_start;

	int errors;
	int cycle_count;
	int sender_gap_pct;
	int sink_stall_pct;

	escape_sof_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte)
	);

	initial begin
		clk = 1'b0;
		forever #ClkHalf clk = ~clk;
	end

	// Receiver: random stalls at the current rate
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [ByteW-1:0] got,
			input logic [ByteW-1:0] want);
		errors++;
		$display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
			want);
	endtask

	// Deframer step on one accepted byte; returns 1 when a beat is due
	function automatic bit deframe_byte(input logic [ByteW-1:0] b, output beat_t res);
		bit due;
		due = 1'b0;
		res = '0;
		case (model_phase)
			PH_HUNT: begin
				if (b == model_escape)
					model_phase = PH_HUNT_ESC;
			end
			PH_HUNT_ESC: begin
				// Anything but start drops back to hunting, escape included
				if (b == model_start) begin
					model_phase    = PH_FRAME;
					model_has_data = 1'b0;
				end else begin
					model_phase = PH_HUNT;
				end
			end
			PH_FRAME: begin
				if (b == model_escape) begin
					model_phase = PH_FRAME_ESC;
				end else begin
					model_has_data = 1'b1;
					due            = 1'b1;
					res.kind       = KIND_DATA;
					res.data       = b;
				end
			end
			default: begin
				// Start check wins when escape and start are the same value
				if (b == model_start) begin
					due            = model_has_data;
					res.kind       = KIND_DONE;
					model_phase    = PH_HUNT;
					model_has_data = 1'b0;
				end else if (b == model_escape) begin
					model_phase    = PH_FRAME;
					model_has_data = 1'b1;
					due            = 1'b1;
					res.kind       = KIND_DATA;
					res.data       = b;
				end else begin
					due            = model_has_data;
					res.kind       = KIND_ABORT;
					model_phase    = PH_HUNT;
					model_has_data = 1'b0;
				end
			end
		endcase
		return due;
	endfunction

	// Compare each output beat with the oldest prediction
	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("beat with none waiting, kind", ByteW'(out_kind), '0);
			end else begin
				want = pending_beats.pop_front();
				if (out_kind !== want.kind)
					report_mismatch("out_kind", ByteW'(out_kind), ByteW'(want.kind));
				if (out_byte !== want.data)
					report_mismatch("out_byte", out_byte, want.data);
			end
		end
	end

	// One input beat; valid stays up on return so back-to-back bytes need no gap
	task automatic send_byte(input logic [ByteW-1:0] b);
		beat_t res;
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (deframe_byte(b, res))
			pending_beats.push_back(res);
	endtask

	task automatic send_seq(input logic [ByteW-1:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// Drain: all predicted beats out, then room for bytes that emit nothing
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_ESCAPE)
			model_escape = val;
		else if (idx == REG_START)
			model_start = val;
	endtask

	task automatic set_framing(input logic [ByteW-1:0] esc, input logic [ByteW-1:0] sof);
		settle();
		write_reg(REG_ESCAPE, esc);
		write_reg(REG_START, sof);
	endtask

	// Biased toward the framing values so escapes and starts show up often
	function automatic logic [ByteW-1:0] random_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return model_escape;
		if (r < 3)
			return model_start;
		return ByteW'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed frames with random payload, some noise and broken openings
	task automatic send_frame_stream(input int n_items);
		int sent;
		int len;
		int pick;
		logic [ByteW-1:0] b;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_byte(random_byte());
				sent++;
			end else if (pick < 15) begin
				// Escape followed by a bad second byte while hunting
				send_byte(model_escape);
				b = random_byte();
				while (b == model_start)
					b = ByteW'($urandom_range(0, 255));
				send_byte(b);
				sent += 2;
			end else begin
				send_byte(model_escape);
				send_byte(model_start);
				len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
				repeat (len) begin
					b = random_byte();
					if (b == model_escape) begin
						// No literal escape exists when escape equals start
						if (model_escape == model_start) begin
							b = b ^ 8'h01;
						end else begin
							send_byte(model_escape);
							sent++;
						end
					end
					send_byte(b);
					sent++;
				end
				send_byte(model_escape);
				if ($urandom_range(0, 3) != 0) begin
					send_byte(model_start);
				end else begin
					b = ByteW'($urandom_range(0, 255));
					while (b == model_start || b == model_escape)
						b = ByteW'($urandom_range(0, 255));
					send_byte(b);
				end
				sent += 4;
			end
		end
	endtask

	// Reset framing: bad hunt byte, literal escape, close, empty frames, abort
	task automatic test_default_framing();
		logic [ByteW-1:0] e;
		logic [ByteW-1:0] s;
		e = EscapeRst;
		s = StartRst;
		send_seq({e, e, s,
			e, s, 8'h00, 8'hFF, e, e, e, s,
			e, s, e, s,
			e, s, 8'h5A, e, 8'h33,
			e, s, e, 8'h77});
	endtask

	// Writes to unmapped indexes leave the framing bytes alone
	task automatic test_unmapped_writes();
		settle();
		write_reg(REG_UNUSED_LO, 8'h00);
		write_reg(REG_UNUSED_HI, 8'hA5);
		send_seq({EscapeRst, StartRst, 8'h11, EscapeRst, StartRst});
	endtask

	// Escape equal to start: a doubled escape in a frame closes it
	task automatic test_escape_equals_start();
		set_framing(8'hAA, 8'hAA);
		send_seq({8'hAA, 8'hAA, 8'h01, 8'hAA, 8'hAA,
			8'hAA, 8'hAA, 8'h02, 8'hAA, 8'h03});
	endtask

	task automatic test_extreme_framing();
		set_framing(8'h00, 8'hFF);
		send_seq({8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF});
		set_framing(8'hFF, 8'h00);
		send_seq({8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00});
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct,
			input logic [ByteW-1:0] esc, input logic [ByteW-1:0] sof, input int n_items);
		set_framing(esc, sof);
		sender_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		send_frame_stream(n_items);
	endtask

	initial begin : run
		logic [ByteW-1:0] rnd_esc;
		logic [ByteW-1:0] rnd_sof;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_ESCAPE;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		model_phase    = PH_HUNT;
		model_has_data = 1'b0;
		model_escape   = EscapeRst;
		model_start    = StartRst;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_framing();
		test_unmapped_writes();
		test_escape_equals_start();
		test_extreme_framing();

		rnd_esc = ByteW'($urandom_range(0, 255));
		rnd_sof = ($urandom_range(0, 3) == 0) ? rnd_esc : 8'($urandom_range(0, 255));
		test_random_traffic(0, 0, EscapeRst, StartRst, 100);
		test_random_traffic(49, 0, rnd_esc, rnd_sof, 100);
		test_random_traffic(0, 49, 8'h00, 8'hFF, 100);
		test_random_traffic(17, 17, 8'hFF, 8'h00, 100);
		rnd_esc = ByteW'($urandom_range(0, 255));
		rnd_sof = ByteW'($urandom_range(0, 255));
		test_random_traffic(17, 17, rnd_esc, rnd_sof, 50);

		settle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: escape_sof_frame_deframer.f
hw/rtl/efd_pkg.sv
hw/rtl/efd_in_stage.sv
hw/rtl/efd_decode.sv
hw/rtl/efd_out_stage.sv
hw/rtl/escape_sof_frame_deframer.sv
hw/rtl/efd_checker.sv
verif/tb_escape_sof_frame_deframer.sv
